FILE: rtl/face_pkg.sv
// Shared types and helpers for the double-precision closeness compare.
`timescale 1ns / 1ps
package face_pkg;

	localparam int ExpW = 11;
	localparam int FracW = 52;
	localparam int MantW = 53;
	localparam int ProdW = 106;
	localparam int ExtW = 56;

	typedef enum logic {
		CfgRel = 1'b0,
		CfgAbs = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic          done;
		logic          close;
	} early_t;

	typedef struct packed {
		logic          nan;
		logic          neg;
		logic          inf;
		logic          zero;
		logic [11:0]   ex;
		logic [MantW-1:0] man;
	} unp_t;

	typedef struct packed {
		logic          nan;
		logic          inf;
		logic          zero;
		logic          neg;
	} pspec_t;

	function automatic unp_t unpack(input logic [63:0] v);
		unp_t u;
		u.nan  = (v[62:52] == 11'h7ff) && (v[51:0] != '0);
		u.inf  = (v[62:52] == 11'h7ff) && (v[51:0] == '0);
		u.neg  = v[63];
		u.zero = (v[62:0] == '0);
		u.ex   = (v[62:52] == '0) ? 12'd1 : {1'b0, v[62:52]};
		u.man  = {(v[62:52] != '0), v[51:0]};
		return u;
	endfunction

	// a <= b by magnitude; NaN never true, negative b true only when both are zero.
	function automatic logic mag_le(input logic [63:0] a, input logic [63:0] b);
		logic an;
		logic bn;
		an = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
		bn = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
		if (an || bn) begin
			return 1'b0;
		end
		if (b[63]) begin
			return (a[62:0] == '0) && (b[62:0] == '0);
		end
		return a[62:0] <= b[62:0];
	endfunction

	// Round a positive value man * 2^(e - 1078) where man has leading one at bit top.
	// Input: normalized mantissa with msb at bit ExtW-1, guard bits below, sticky.
	function automatic logic [62:0] round_pack(input logic signed [13:0] e,
			input logic [ExtW-1:0] m, input logic sticky_in);
		logic [ExtW-1:0] sh;
		logic            st;
		logic [12:0]     amt;
		logic [52:0]     keep;
		logic            g;
		logic            s;
		logic [53:0]     r;
		logic signed [13:0] eo;
		logic [62:0]     res;
		st = sticky_in;
		sh = m;
		eo = e;
		if (e < 14'sd1) begin
			amt = 13'(14'sd1 - e);
			if (amt > 13'd56) begin
				amt = 13'd56;
			end
			st = st | ((m & ((ExtW'(1) << amt[5:0]) - ExtW'(1))) != '0)
				| (amt == 13'd56 && m != '0);
			sh = (amt == 13'd56) ? '0 : (m >> amt[5:0]);
			eo = 14'sd0;
		end
		keep = sh[ExtW-1:3];
		g = sh[2];
		s = (sh[1:0] != '0) | st;
		r = {1'b0, keep} + 54'(g & (s | keep[0]));
		if (r[53]) begin
			r = r >> 1;
			eo = eo + 14'sd1;
		end
		if (eo == 14'sd0 && r[52]) begin
			eo = 14'sd1;
		end
		if (eo >= 14'sd2047) begin
			res = {11'h7ff, 52'd0};
		end else begin
			res = {eo[10:0], r[51:0]};
		end
		return res;
	endfunction

endpackage

FILE: rtl/float_approx_equal_compare_top.sv
// Top level of the pipelined double-precision closeness compare.
//   channel    dir   handshake              fields
//   config     in    cfg_we                 cfg_index, cfg_data
//   operands   in    in_valid / in_ready    first_value, second_value
//   result     out   out_valid / out_ready  is_close
// One item enters per cycle while in_ready is high; its result then moves through the stages in order.
// Stages: align and add, normalize and partial products, round difference and sum
// products, normalize product, round product, final compare.
// Reset clears the valid bits and both tolerance registers.
// A stage holds while the next one is full and held; empty stages still fill, so
// in_ready drops only when all six stages hold items and out_ready is low.
`timescale 1ns / 1ps
module float_approx_equal_compare_top import face_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] first_value,
	input  logic [63:0] second_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_close
);
	logic [63:0] rel_q;
	logic [63:0] abs_q;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic v_s6;
	logic en1;
	logic en2;
	logic en3;
	logic en4;
	logic en5;
	logic en6;
	early_t early_s1;
	early_t early_s2;
	early_t early_s3;
	early_t early_s4;
	early_t early_s5;
	logic [63:0] larger_s1;
	logic signed [13:0] dexp_s1;
	logic [ExtW:0] dsum_s1;
	logic dst_s1;
	logic [63:0] diff_s5;
	logic [63:0] prod_s5;
	logic absok_s5;
	logic close_s6;

	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s6;
	assign is_close = close_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q <= '0;
			abs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CfgRel: rel_q <= cfg_data;
				CfgAbs: abs_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			early_s2 <= early_s1;
		end
		if (en3) begin
			early_s3 <= early_s2;
		end
		if (en4) begin
			early_s4 <= early_s3;
		end
		if (en5) begin
			early_s5 <= early_s4;
		end
		if (en6) begin
			close_s6 <= early_s5.done ? early_s5.close
				: (absok_s5 || mag_le(diff_s5, prod_s5));
		end
	end

	face_diff i_diff (
		.clk(clk),
		.en(en1),
		.a(first_value),
		.b(second_value),
		.early_s1(early_s1),
		.larger_s1(larger_s1),
		.dexp_s1(dexp_s1),
		.dsum_s1(dsum_s1),
		.dst_s1(dst_s1)
	);

	face_mul i_mul (
		.clk(clk),
		.en2(en2),
		.en3(en3),
		.en4(en4),
		.en5(en5),
		.rel(rel_q),
		.absb(abs_q),
		.larger_s1(larger_s1),
		.dexp_s1(dexp_s1),
		.dsum_s1(dsum_s1),
		.dst_s1(dst_s1),
		.diff_s5(diff_s5),
		.prod_s5(prod_s5),
		.absok_s5(absok_s5)
	);

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before its item was taken");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(is_close))
		else $error("is_close changed while its item waited");
	a_hs_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid}))
		else $error("handshake signal unknown");
	a_close_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(is_close))
		else $error("is_close unknown on a valid item");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("in_ready low with an empty first stage");
`endif
endmodule

FILE: rtl/face_diff.sv
// Front stage: classify operands, align, add or subtract magnitudes, find the larger.
`timescale 1ns / 1ps
module face_diff import face_pkg::*; (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output early_t       early_s1,
	output logic [63:0]  larger_s1,
	output logic signed [13:0] dexp_s1,
	output logic [ExtW:0] dsum_s1,
	output logic         dst_s1
);
	unp_t ua;
	unp_t ub;
	unp_t ux;
	unp_t uy;
	logic swap;
	logic [11:0] dd;
	logic [ExtW-1:0] xm;
	logic [ExtW-1:0] ym;
	logic [ExtW-1:0] ys;
	logic st;
	early_t e;

	always_comb begin
		ua = unpack(a);
		ub = unpack(b);
		swap = b[62:0] > a[62:0];
		ux = swap ? ub : ua;
		uy = swap ? ua : ub;
		dd = ux.ex - uy.ex;
		xm = {ux.man, 3'b000};
		ym = {uy.man, 3'b000};
		if (dd >= 12'd56) begin
			ys = '0;
			st = (uy.man != '0);
		end else begin
			ys = ym >> dd[5:0];
			st = (ym & ((ExtW'(1) << dd[5:0]) - ExtW'(1))) != '0;
		end
		e.done  = 1'b1;
		e.close = 1'b0;
		if (ua.nan || ub.nan) begin
			e.close = 1'b0;
		end else if (ua.inf || ub.inf) begin
			e.close = (a == b);
		end else if (a == b || (ua.zero && ub.zero)) begin
			e.close = 1'b1;
		end else begin
			e.done = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			early_s1  <= e;
			larger_s1 <= {1'b0, swap ? b[62:0] : a[62:0]};
			dexp_s1   <= 14'(ux.ex);
			dsum_s1   <= (ua.neg == ub.neg) ? ({1'b0, xm} - {1'b0, ys} - (ExtW+1)'(st))
				: ({1'b0, xm} + {1'b0, ys});
			dst_s1    <= st;
		end
	end
endmodule

FILE: rtl/face_mul.sv
// Middle stages: normalize and round the difference, multiply for the relative bound.
`timescale 1ns / 1ps
module face_mul import face_pkg::*; (
	input  logic         clk,
	input  logic         en2,
	input  logic         en3,
	input  logic         en4,
	input  logic         en5,
	input  logic [63:0]  rel,
	input  logic [63:0]  absb,
	input  logic [63:0]  larger_s1,
	input  logic signed [13:0] dexp_s1,
	input  logic [ExtW:0] dsum_s1,
	input  logic         dst_s1,
	output logic [63:0]  diff_s5,
	output logic [63:0]  prod_s5,
	output logic         absok_s5
);
	logic [ExtW:0] n;
	logic [5:0] lz;
	logic signed [13:0] ee;
	unp_t ur;
	unp_t ul;
	logic [ExtW-1:0] dm_s2;
	logic dsticky_s2;
	logic signed [13:0] dexp_s2;
	logic dzero_s2;
	logic [53:0] pphh_s2;
	logic [52:0] pphl_s2;
	logic [52:0] pplh_s2;
	logic [51:0] ppll_s2;
	logic signed [13:0] pe_s2;
	pspec_t ps_s2;
	logic [62:0] diff_c;
	logic [ProdW-1:0] psum;
	logic [63:0] diff_s3;
	logic [ProdW-1:0] pm_s3;
	logic signed [13:0] pe_s3;
	pspec_t ps_s3;
	logic [6:0] plz;
	logic [ProdW-1:0] pn;
	logic [63:0] diff_s4;
	logic absok_s4;
	logic [ExtW-1:0] pm_s4;
	logic pst_s4;
	logic signed [13:0] pe_s4;
	pspec_t ps_s4;
	logic [63:0] p;

	always_comb begin
		ee = dexp_s1 + 14'sd1;
		lz = '0;
		for (int i = 0; i <= ExtW; i++) begin
			if (dsum_s1[i]) begin
				lz = 6'(ExtW - i);
			end
		end
		n = dsum_s1 << lz;
		ur = unpack(rel);
		ul = unpack(larger_s1);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			dm_s2      <= n[ExtW:1];
			dsticky_s2 <= n[0] | dst_s1;
			dexp_s2    <= ee - $signed(14'(lz));
			dzero_s2   <= (dsum_s1 == '0);
			pphh_s2    <= 54'(ur.man[52:26]) * 54'(ul.man[52:26]);
			pphl_s2    <= 53'(ur.man[52:26]) * 53'(ul.man[25:0]);
			pplh_s2    <= 53'(ur.man[25:0]) * 53'(ul.man[52:26]);
			ppll_s2    <= 52'(ur.man[25:0]) * 52'(ul.man[25:0]);
			pe_s2      <= $signed(14'(ur.ex)) + $signed(14'(ul.ex)) - 14'sd1023;
			ps_s2.nan  <= ur.nan;
			ps_s2.inf  <= ur.inf;
			ps_s2.zero <= ur.zero;
			ps_s2.neg  <= ur.neg;
		end
	end

	always_comb begin
		diff_c = round_pack(dexp_s2, dm_s2, dsticky_s2);
		if (dzero_s2) begin
			diff_c = '0;
		end
		psum = (ProdW'(pphh_s2) << 52) + ((ProdW'(pphl_s2) + ProdW'(pplh_s2)) << 26)
			+ ProdW'(ppll_s2);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			diff_s3 <= {1'b0, diff_c};
			pm_s3   <= psum;
			pe_s3   <= pe_s2;
			ps_s3   <= ps_s2;
		end
	end

	always_comb begin
		plz = '0;
		for (int i = 0; i < ProdW; i++) begin
			if (pm_s3[i]) begin
				plz = 7'(ProdW - 1 - i);
			end
		end
		pn = pm_s3 << plz;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			diff_s4  <= diff_s3;
			absok_s4 <= mag_le(diff_s3, absb);
			pm_s4    <= pn[ProdW-1:ProdW-ExtW];
			pst_s4   <= (pn[ProdW-ExtW-1:0] != '0);
			pe_s4    <= pe_s3 + 14'sd1 - $signed(14'(plz));
			ps_s4    <= ps_s3;
		end
	end

	always_comb begin
		p = {ps_s4.neg, round_pack(pe_s4, pm_s4, pst_s4)};
		if (ps_s4.zero) begin
			p = {ps_s4.neg, 63'd0};
		end
		if (ps_s4.inf) begin
			p = {ps_s4.neg, 11'h7ff, 52'd0};
		end
		if (ps_s4.nan) begin
			p = 64'h7ff8000000000000;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			prod_s5  <= p;
			diff_s5  <= diff_s4;
			absok_s5 <= absok_s4;
		end
	end
endmodule
